### hw/rtl/bts_pkg.sv
// bts_pkg: shared constants, register index codes, sequencer states and control
// structs for the bilinear texture sampler; no dependencies
package bts_pkg;

  localparam int unsigned BTS_MAX_TEXELS  = 65536;
  localparam int unsigned BTS_WEIGHT_BITS = 8;

  localparam int unsigned IDX_W   = 16;
  localparam int unsigned COORD_W = 18;
  localparam int unsigned SIZE_W  = 9;
  localparam int unsigned CH_W    = 8;
  localparam int unsigned TEXEL_W = 32;
  localparam int unsigned CFG_A_W = 2;
  localparam int unsigned IN_TDATA_W  = 88;
  localparam int unsigned OUT_TDATA_W = 32;

  typedef enum logic [CFG_A_W-1:0] {
    CFG_TEX_WIDTH  = 2'd0,
    CFG_TEX_HEIGHT = 2'd1,
    CFG_HAS_ALPHA  = 2'd2
  } bts_cfg_idx_t;

  typedef enum logic [1:0] {
    SEL_00 = 2'd0,
    SEL_01 = 2'd1,
    SEL_10 = 2'd2,
    SEL_11 = 2'd3
  } bts_sel_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCALE,
    ST_INDEX,
    ST_ROW,
    ST_RD0,
    ST_RD1,
    ST_RD2,
    ST_RD3,
    ST_CAP,
    ST_HLERP,
    ST_OUT
  } bts_state_t;

  typedef struct packed {
    logic     load;
    logic     scale;
    logic     index;
    logic     row;
    bts_sel_t sel;
  } bts_coord_ctl_t;

  typedef struct packed {
    logic [3:0] cap;
    logic       hlerp;
  } bts_filt_ctl_t;

endpackage

### hw/rtl/bts_texmem.sv
// bts_texmem: single-port texel memory, registered read
// entries past the depth are dropped on write and read back as zero; uses bts_pkg
module bts_texmem import bts_pkg::*; #(
  parameter int unsigned MAX_TEXELS = BTS_MAX_TEXELS
) (
  input  logic               clk,
  input  logic               we,
  input  logic [IDX_W-1:0]   addr,
  input  logic [TEXEL_W-1:0] wdata,
  output logic [TEXEL_W-1:0] rdata
);

  localparam int unsigned AW = $clog2(MAX_TEXELS);

  logic [TEXEL_W-1:0] texel_mem [MAX_TEXELS];
  logic [TEXEL_W-1:0] q_r;
  logic               zero_r;
  logic [31:0]        addr_ext;
  logic               in_range;

  assign addr_ext = 32'(addr);
  assign in_range = addr_ext < 32'(MAX_TEXELS);

  always_ff @(posedge clk) begin
    if (we && in_range) begin
      texel_mem[addr_ext[AW-1:0]] <= wdata;
    end
    q_r    <= texel_mem[addr_ext[AW-1:0]];
    zero_r <= !in_range;
  end

  assign rdata = zero_r ? '0 : q_r;

endmodule

### hw/rtl/bts_coord.sv
// bts_coord: coordinate clamp, scale, neighbor index and weight generation
// steps through scale, index and row-base registers; uses bts_pkg
module bts_coord import bts_pkg::*; #(
  parameter int unsigned WEIGHT_BITS = BTS_WEIGHT_BITS
) (
  input  logic                   clk,
  input  bts_coord_ctl_t         ctl,
  input  logic [COORD_W-1:0]     u_coord,
  input  logic [COORD_W-1:0]     v_coord,
  input  logic [SIZE_W-1:0]      tex_width,
  input  logic [SIZE_W-1:0]      tex_height,
  output logic [IDX_W-1:0]       rd_idx,
  output logic [WEIGHT_BITS-1:0] fx,
  output logic [WEIGHT_BITS-1:0] fy
);

  localparam int unsigned P_W = 25;

  function automatic logic [16:0] clamp_coord(logic [COORD_W-1:0] c);
    logic [16:0] r;
    if (c[COORD_W-1]) begin
      r = '0;
    end else if (c[COORD_W-2:0] > 17'h10000) begin
      r = 17'h10000;
    end else begin
      r = c[16:0];
    end
    return r;
  endfunction

  function automatic logic [SIZE_W-1:0] fit_size(logic [SIZE_W-1:0] s);
    logic [SIZE_W-1:0] r;
    if (s == '0) begin
      r = 9'd1;
    end else if (s > 9'd256) begin
      r = 9'd256;
    end else begin
      r = s;
    end
    return r;
  endfunction

  logic [16:0]            cu_r, cv_r;
  logic [SIZE_W-1:0]      w_r, h_r;
  logic [P_W-1:0]         px_r, py_r;
  logic [7:0]             ix_r, ix1_r, iy_r, iy1_r;
  logic [WEIGHT_BITS-1:0] fx_r, fy_r;
  logic [IDX_W-1:0]       row0_r, row1_r;

  logic [SIZE_W-1:0] wm1, hm1, ixf, iyf, ixc, iyc, ixp, iyp;
  logic [IDX_W-1:0]  base;
  logic [7:0]        col;

  assign wm1 = w_r - 9'd1;
  assign hm1 = h_r - 9'd1;
  assign ixf = px_r[24:16];
  assign iyf = py_r[24:16];
  assign ixc = (ixf > wm1) ? wm1 : ixf;
  assign iyc = (iyf > hm1) ? hm1 : iyf;
  assign ixp = ixc + 9'd1;
  assign iyp = iyc + 9'd1;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cu_r <= clamp_coord(u_coord);
      cv_r <= clamp_coord(v_coord);
      w_r  <= fit_size(tex_width);
      h_r  <= fit_size(tex_height);
    end
    if (ctl.scale) begin
      px_r <= P_W'(cu_r * w_r);
      py_r <= P_W'(cv_r * h_r);
    end
    if (ctl.index) begin
      ix_r  <= ixc[7:0];
      iy_r  <= iyc[7:0];
      ix1_r <= (ixp > wm1) ? wm1[7:0] : ixp[7:0];
      iy1_r <= (iyp > hm1) ? hm1[7:0] : iyp[7:0];
      fx_r  <= px_r[16-WEIGHT_BITS +: WEIGHT_BITS];
      fy_r  <= py_r[16-WEIGHT_BITS +: WEIGHT_BITS];
    end
    if (ctl.row) begin
      row0_r <= IDX_W'(iy_r * w_r);
      row1_r <= IDX_W'(iy1_r * w_r);
    end
  end

  always_comb begin
    case (ctl.sel)
      SEL_00:  begin base = row0_r; col = ix_r;  end
      SEL_01:  begin base = row0_r; col = ix1_r; end
      SEL_10:  begin base = row1_r; col = ix_r;  end
      SEL_11:  begin base = row1_r; col = ix1_r; end
      default: begin base = row0_r; col = ix_r;  end
    endcase
  end

  assign rd_idx = base + IDX_W'(col);
  assign fx     = fx_r;
  assign fy     = fy_r;

endmodule

### hw/rtl/bts_filter.sv
// bts_filter: texel capture and two-pass bilinear blend per channel
// horizontal lerp registered, vertical lerp combinational; uses bts_pkg
module bts_filter import bts_pkg::*; #(
  parameter int unsigned WEIGHT_BITS = BTS_WEIGHT_BITS
) (
  input  logic                   clk,
  input  bts_filt_ctl_t          ctl,
  input  logic [TEXEL_W-1:0]     rdata,
  input  logic [WEIGHT_BITS-1:0] fx,
  input  logic [WEIGHT_BITS-1:0] fy,
  input  logic                   has_alpha,
  output logic [TEXEL_W-1:0]     pixel
);

  localparam int unsigned LW = WEIGHT_BITS + CH_W + 1;

  function automatic logic [CH_W-1:0] lerp(logic [CH_W-1:0] a, logic [CH_W-1:0] b,
                                           logic [WEIGHT_BITS-1:0] f);
    logic [WEIGHT_BITS:0] g;
    logic [LW-1:0]        s;
    g = {1'b1, {WEIGHT_BITS{1'b0}}} - {1'b0, f};
    s = LW'(a) * LW'(g) + LW'(b) * LW'(f);
    return s[WEIGHT_BITS +: CH_W];
  endfunction

  logic [TEXEL_W-1:0] t_r [4];
  logic [CH_W-1:0]    top_r [4];
  logic [CH_W-1:0]    bot_r [4];
  logic [CH_W-1:0]    v [4];

  always_ff @(posedge clk) begin
    for (int k = 0; k < 4; k++) begin
      if (ctl.cap[k]) begin
        t_r[k] <= rdata;
      end
    end
    if (ctl.hlerp) begin
      for (int c = 0; c < 4; c++) begin
        top_r[c] <= lerp(t_r[0][c*CH_W +: CH_W], t_r[1][c*CH_W +: CH_W], fx);
        bot_r[c] <= lerp(t_r[2][c*CH_W +: CH_W], t_r[3][c*CH_W +: CH_W], fx);
      end
    end
  end

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      v[c] = lerp(top_r[c], bot_r[c], fy);
    end
  end

  assign pixel = {has_alpha ? v[3] : {CH_W{1'b0}}, v[2], v[1], v[0]};

endmodule

### hw/rtl/bilinear_texture_sampler_top.sv
// bilinear_texture_sampler_top: texture store plus bilinear sampler with edge clamp
// instantiates bts_texmem, bts_coord and bts_filter; uses bts_pkg
//
// usage:
//   in_ channel carries one beat per item; in_tuser selects the kind:
//   0 writes one RGBA texel at texel_addr, 1 samples the texture at u, v.
//   a write returns nothing.
//   a sample steps through the scale, index, row-base, four read, capture and
//   blend states and the output step before the block is ready again, and
//   returns one beat on out_; out_tvalid rises once the output step loads it.
//   the four texel reads share the single memory port, one per cycle.
//   one item is in flight at a time; in_tready is high while the sequencer idles.
//   the result sits in an output register, so a new item is accepted while it
//   waits; a stalled receiver holds the next result in its last step and the
//   block takes no further item until the register frees.
//   cfg_ writes set width, height and alpha enable; write only while idle.
//   reset (rst_n low, synchronous) clears the sequencer, output valid and
//   registers to 256 x 256 with alpha on; texel memory content is not cleared.
module bilinear_texture_sampler_top import bts_pkg::*; #(
  parameter int unsigned MAX_TEXELS  = BTS_MAX_TEXELS,
  parameter int unsigned WEIGHT_BITS = BTS_WEIGHT_BITS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // texel_addr, in_red, in_green, in_blue, in_alpha, u_coord, v_coord, zero pad
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // mode
  input  logic                   in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // out_red, out_green, out_blue, out_alpha
  output logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   cfg_we,
  input  logic [CFG_A_W-1:0]     cfg_addr,
  input  logic [SIZE_W-1:0]      cfg_wdata
);

  bts_state_t state_r, state_nxt;

  logic [SIZE_W-1:0] tex_width_r, tex_height_r;
  logic              has_alpha_r;
  logic              out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;

  logic                   in_acc, mem_we, out_load, out_free;
  logic [IDX_W-1:0]       texel_addr, rd_idx, mem_addr;
  logic [TEXEL_W-1:0]     wr_texel, rdata, pixel;
  logic [COORD_W-1:0]     u_coord, v_coord;
  logic [WEIGHT_BITS-1:0] fx, fy;
  bts_coord_ctl_t         coord_ctl;
  bts_filt_ctl_t          filt_ctl;

  assign texel_addr = in_tdata[15:0];
  assign wr_texel   = in_tdata[47:16];
  assign u_coord    = in_tdata[65:48];
  assign v_coord    = in_tdata[83:66];

  assign in_acc   = in_tvalid && in_tready;
  assign mem_we   = in_acc && !in_tuser;
  assign mem_addr = (state_r == ST_IDLE) ? texel_addr : rd_idx;
  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_acc && in_tuser) state_nxt = ST_SCALE;
      ST_SCALE: state_nxt = ST_INDEX;
      ST_INDEX: state_nxt = ST_ROW;
      ST_ROW:   state_nxt = ST_RD0;
      ST_RD0:   state_nxt = ST_RD1;
      ST_RD1:   state_nxt = ST_RD2;
      ST_RD2:   state_nxt = ST_RD3;
      ST_RD3:   state_nxt = ST_CAP;
      ST_CAP:   state_nxt = ST_HLERP;
      ST_HLERP: state_nxt = ST_OUT;
      ST_OUT:   if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    out_load  = 1'b0;
    coord_ctl = '{load: 1'b0, scale: 1'b0, index: 1'b0, row: 1'b0, sel: SEL_00};
    filt_ctl  = '{cap: 4'b0000, hlerp: 1'b0};
    case (state_r)
      ST_IDLE: begin
        in_tready      = 1'b1;
        coord_ctl.load = in_acc && in_tuser;
      end
      ST_SCALE: coord_ctl.scale = 1'b1;
      ST_INDEX: coord_ctl.index = 1'b1;
      ST_ROW:   coord_ctl.row = 1'b1;
      ST_RD0:   coord_ctl.sel = SEL_00;
      ST_RD1: begin
        coord_ctl.sel = SEL_01;
        filt_ctl.cap  = 4'b0001;
      end
      ST_RD2: begin
        coord_ctl.sel = SEL_10;
        filt_ctl.cap  = 4'b0010;
      end
      ST_RD3: begin
        coord_ctl.sel = SEL_11;
        filt_ctl.cap  = 4'b0100;
      end
      ST_CAP:   filt_ctl.cap = 4'b1000;
      ST_HLERP: filt_ctl.hlerp = 1'b1;
      ST_OUT:   out_load = out_free;
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_valid_r  <= 1'b0;
      tex_width_r  <= 9'd256;
      tex_height_r <= 9'd256;
      has_alpha_r  <= 1'b1;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_addr)
          CFG_TEX_WIDTH:  tex_width_r  <= cfg_wdata;
          CFG_TEX_HEIGHT: tex_height_r <= cfg_wdata;
          CFG_HAS_ALPHA:  has_alpha_r  <= cfg_wdata[0];
          default:        has_alpha_r  <= has_alpha_r;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= pixel;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  bts_texmem #(
    .MAX_TEXELS(MAX_TEXELS)
  ) u_texmem (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (wr_texel),
    .rdata (rdata)
  );

  bts_coord #(
    .WEIGHT_BITS(WEIGHT_BITS)
  ) u_coordgen (
    .clk        (clk),
    .ctl        (coord_ctl),
    .u_coord    (u_coord),
    .v_coord    (v_coord),
    .tex_width  (tex_width_r),
    .tex_height (tex_height_r),
    .rd_idx     (rd_idx),
    .fx         (fx),
    .fy         (fy)
  );

  bts_filter #(
    .WEIGHT_BITS(WEIGHT_BITS)
  ) u_filter (
    .clk       (clk),
    .ctl       (filt_ctl),
    .rdata     (rdata),
    .fx        (fx),
    .fy        (fy),
    .has_alpha (has_alpha_r),
    .pixel     (pixel)
  );

  a_write_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> state_r == ST_IDLE)
    else $error("texel write outside idle");

  a_write_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |=> state_r == ST_IDLE)
    else $error("texel write did not return to idle");

  a_sample_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_tuser) |=> state_r == ST_SCALE)
    else $error("sample did not start sequence");

  a_result_from_out: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_OUT)
    else $error("result appeared outside output step");

  a_out_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_OUT && out_valid_r && !out_tready) |=> state_r == ST_OUT)
    else $error("pending result overwritten");

endmodule

### tb/bts_tb_pkg.sv
`timescale 1ns / 1ps
// bts_tb_pkg: beat layouts, item kinds and coordinate helpers shared by the
// sampler testbench top and its checker; depends on bts_pkg
package bts_tb_pkg;
  import bts_pkg::*;

  typedef enum logic {
    ITEM_WRITE  = 1'b0,
    ITEM_SAMPLE = 1'b1
  } item_kind_t;

  // red in the lowest byte
  typedef struct packed {
    logic [CH_W-1:0] alpha;
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] red;
  } rgba_t;

  // in_tdata layout, addr in the lowest bits
  typedef struct packed {
    logic [3:0]         pad;
    logic [COORD_W-1:0] v;
    logic [COORD_W-1:0] u;
    rgba_t              texel;
    logic [IDX_W-1:0]   addr;
  } in_beat_t;

  typedef struct packed {
    logic [SIZE_W-1:0]          lo;
    logic [SIZE_W-1:0]          hi;
    logic [BTS_WEIGHT_BITS-1:0] frac;
  } axis_t;

  function automatic int unsigned fit_size(logic [SIZE_W-1:0] s);
    if (s == 0) return 1;
    if (s > 256) return 256;
    return s;
  endfunction

  // clamp a Q2.16 coordinate to 0..1, scale by n, split into index and weight
  function automatic axis_t locate(logic [COORD_W-1:0] c, int unsigned n);
    axis_t r;
    int unsigned q;
    int unsigned p;
    int unsigned whole;
    if (c[COORD_W-1]) q = 0;
    else if (c > 18'd65536) q = 65536;
    else q = 32'(c);
    p = q * n;
    r.frac = BTS_WEIGHT_BITS'((p >> (16 - BTS_WEIGHT_BITS)) & ((1 << BTS_WEIGHT_BITS) - 1));
    whole = p >> 16;
    if (whole > n - 1) whole = n - 1;
    r.lo = SIZE_W'(whole);
    r.hi = SIZE_W'((whole + 1 > n - 1) ? n - 1 : whole + 1);
    return r;
  endfunction

endpackage

### tb/bts_checker.sv
`timescale 1ns / 1ps
// bts_checker: watches the sampler's channels and config port, keeps its own
// texture and register copies, predicts each filtered pixel and compares it
// depends on bts_pkg and bts_tb_pkg
module bts_checker
  import bts_pkg::*;
  import bts_tb_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   in_tuser,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   cfg_we,
  input  logic [CFG_A_W-1:0]     cfg_addr,
  input  logic [SIZE_W-1:0]      cfg_wdata,
  output int unsigned            fail_count,
  output int unsigned            pending
);

  logic [TEXEL_W-1:0] texels [0:BTS_MAX_TEXELS-1];
  int unsigned        tex_w;
  int unsigned        tex_h;
  logic               alpha_on;
  rgba_t              filtered_q [$];
  string              lane_name [0:3];

  initial begin
    lane_name[0] = "out_red";
    lane_name[1] = "out_green";
    lane_name[2] = "out_blue";
    lane_name[3] = "out_alpha";
  end

  function automatic int unsigned blend(int unsigned a, int unsigned b, int unsigned f);
    int unsigned one;
    one = 1 << BTS_WEIGHT_BITS;
    return (a * (one - f) + b * f) >> BTS_WEIGHT_BITS;
  endfunction

  function automatic rgba_t filter_sample(logic [COORD_W-1:0] u, logic [COORD_W-1:0] v);
    axis_t              ax;
    axis_t              ay;
    logic [TEXEL_W-1:0] t00;
    logic [TEXEL_W-1:0] t01;
    logic [TEXEL_W-1:0] t10;
    logic [TEXEL_W-1:0] t11;
    rgba_t              pix;
    int unsigned        upper;
    int unsigned        lower;
    ax = locate(u, tex_w);
    ay = locate(v, tex_h);
    t00 = texels[ay.lo * tex_w + ax.lo];
    t01 = texels[ay.lo * tex_w + ax.hi];
    t10 = texels[ay.hi * tex_w + ax.lo];
    t11 = texels[ay.hi * tex_w + ax.hi];
    for (int ch = 0; ch < 4; ch++) begin
      upper = blend(t00[8*ch +: 8], t01[8*ch +: 8], ax.frac);
      lower = blend(t10[8*ch +: 8], t11[8*ch +: 8], ax.frac);
      pix[8*ch +: 8] = 8'(blend(upper, lower, ay.frac));
    end
    if (!alpha_on) pix.alpha = '0;
    return pix;
  endfunction

  always @(posedge clk) begin : monitor
    in_beat_t beat;
    rgba_t    got;
    rgba_t    want;
    if (!rst_n) begin
      tex_w = 256;
      tex_h = 256;
      alpha_on = 1'b1;
      fail_count = 0;
      pending <= 0;
    end else begin
      if (cfg_we) begin
        case (bts_cfg_idx_t'(cfg_addr))
          CFG_TEX_WIDTH: begin
            tex_w = fit_size(cfg_wdata);
          end
          CFG_TEX_HEIGHT: begin
            tex_h = fit_size(cfg_wdata);
          end
          CFG_HAS_ALPHA: begin
            alpha_on = cfg_wdata[0];
          end
          default: begin
          end
        endcase
      end
      if (in_tvalid && in_tready) begin
        beat = in_beat_t'(in_tdata);
        if (item_kind_t'(in_tuser) == ITEM_WRITE) texels[beat.addr] = beat.texel;
        else filtered_q = {filtered_q, filter_sample(beat.u, beat.v)};
      end
      if (out_tvalid && out_tready) begin
        got = rgba_t'(out_tdata);
        if (filtered_q.size() == 0) begin
          $display("%0t: out beat %08h with no sample pending", $time, got);
          fail_count++;
        end else begin
          want = filtered_q.pop_front();
          for (int ch = 0; ch < 4; ch++) begin
            if (got[8*ch +: 8] !== want[8*ch +: 8]) begin
              $display("%0t: %s expected %02h actual %02h", $time, lane_name[ch],
                       want[8*ch +: 8], got[8*ch +: 8]);
              fail_count++;
            end
          end
        end
      end
      pending <= filtered_q.size();
    end
  end

endmodule

### tb/tb_bilinear_texture_sampler_top.sv
`timescale 1ns / 1ps
// tb_bilinear_texture_sampler_top: drives texel writes, samples and register
// settings into the sampler with bursty input and stalling output; bts_checker
// does the prediction. depends on bts_pkg, bts_tb_pkg and bts_checker
module tb_bilinear_texture_sampler_top;
  import bts_pkg::*;
  import bts_tb_pkg::*;

  localparam int unsigned IDLE_LIMIT     = 4000;
  localparam int unsigned SQUEEZE_CYCLES = 250;
  localparam int unsigned SETTLE_CYCLES  = 16;
  localparam int unsigned PHASES         = 10;
  localparam int unsigned PHASE_ITEMS    = 63;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_we;
  logic [CFG_A_W-1:0]     cfg_addr;
  logic [SIZE_W-1:0]      cfg_wdata;
  int unsigned            fail_count;
  int unsigned            pending;

  int unsigned cur_w;
  int unsigned cur_h;
  bit          written [0:BTS_MAX_TEXELS-1];
  int unsigned burst_left;
  bit          steady;
  bit          squeeze_req;
  bit          squeeze_done;
  int unsigned rx_cycle;
  int unsigned rx_style;
  int unsigned idle_cycles = 0;
  int unsigned sent_items;
  int unsigned phase_end;
  int unsigned phase_n;

  bilinear_texture_sampler_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  bts_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic in_beat_t random_beat();
    in_beat_t b;
    b = '0;
    b.addr = IDX_W'($urandom);
    b.texel = $urandom;
    b.u = COORD_W'($urandom);
    b.v = COORD_W'($urandom);
    return b;
  endfunction

  function automatic logic [COORD_W-1:0] pick_coord();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return 18'd65536;
      2, 3: return COORD_W'($urandom);
      default: return COORD_W'($urandom_range(0, 65536));
    endcase
  endfunction

  // hold the beat until accepted, then maybe close the burst with a gap
  task automatic send_beat(item_kind_t kind, in_beat_t beat);
    in_tvalid <= 1'b1;
    in_tuser <= kind;
    in_tdata <= beat;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent_items++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (!steady && $urandom_range(0, 3) != 0) begin
        in_tvalid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  endtask

  task automatic put_texel(int unsigned addr, logic [TEXEL_W-1:0] texel);
    in_beat_t beat;
    beat = random_beat();
    beat.addr = IDX_W'(addr);
    beat.texel = texel;
    send_beat(ITEM_WRITE, beat);
    written[addr] = 1'b1;
  endtask

  // make sure all four neighbors hold data before sampling
  task automatic sample_at(logic [COORD_W-1:0] u, logic [COORD_W-1:0] v);
    axis_t       ax;
    axis_t       ay;
    int unsigned tex_idx;
    in_beat_t    beat;
    ax = locate(u, cur_w);
    ay = locate(v, cur_h);
    for (int k = 0; k < 4; k++) begin
      tex_idx = (k[1] ? ay.hi : ay.lo) * cur_w + (k[0] ? ax.hi : ax.lo);
      if (!written[tex_idx]) put_texel(tex_idx, $urandom);
    end
    beat = random_beat();
    beat.u = u;
    beat.v = v;
    send_beat(ITEM_SAMPLE, beat);
  endtask

  task automatic random_item();
    int unsigned addr;
    if ($urandom_range(0, 9) < 3) begin
      addr = $urandom_range(0, 65535);
      if ($urandom_range(0, 3) != 0) addr = $urandom_range(0, cur_w * cur_h - 1);
      put_texel(addr, $urandom);
    end else begin
      sample_at(pick_coord(), pick_coord());
    end
  endtask

  task automatic quiesce();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic configure(logic [SIZE_W-1:0] w, logic [SIZE_W-1:0] h, logic alpha);
    cfg_we <= 1'b1;
    cfg_addr <= CFG_TEX_WIDTH;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_addr <= CFG_TEX_HEIGHT;
    cfg_wdata <= h;
    @(posedge clk);
    cfg_addr <= CFG_HAS_ALPHA;
    cfg_wdata <= {{(SIZE_W-1){1'b0}}, alpha};
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_w = fit_size(w);
    cur_h = fit_size(h);
  endtask

  // receiver: switches between random ready styles, plus one long squeeze on request
  initial begin
    out_tready = 1'b0;
    squeeze_done = 1'b0;
    rx_cycle = 0;
    rx_style = 0;
    forever begin
      @(posedge clk);
      if (squeeze_req && !squeeze_done) begin
        squeeze_done = 1'b1;
        out_tready <= 1'b0;
        repeat (SQUEEZE_CYCLES) @(posedge clk);
      end else begin
        if (rx_cycle % 64 == 0) rx_style = $urandom_range(0, 3);
        rx_cycle++;
        case (rx_style)
          0: out_tready <= 1'b1;
          1: out_tready <= $urandom_range(0, 1);
          2: out_tready <= ($urandom_range(0, 4) != 0);
          default: out_tready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = ITEM_WRITE;
    cfg_we = 1'b0;
    cfg_addr = CFG_TEX_WIDTH;
    cfg_wdata = '0;
    squeeze_req = 1'b0;
    steady = 1'b0;
    burst_left = 1;
    cur_w = 256;
    cur_h = 256;
    sent_items = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: color extremes, weight extremes, edge and negative coordinates
    put_texel(0, 32'hFFFF_FFFF);
    put_texel(1, 32'h0000_0000);
    put_texel(256, 32'h0000_0000);
    put_texel(257, 32'hFFFF_FFFF);
    put_texel(16'hFFFF, 32'hFFFF_FFFF);
    put_texel(16'hFFFE, 32'h00FF_00FF);
    put_texel(16'hFEFF, 32'h8040_20FF);
    sample_at(18'd0, 18'd0);
    sample_at(18'd128, 18'd128);
    sample_at(18'd255, 18'd255);
    sample_at(18'd65535, 18'd65535);
    sample_at(18'd65536, 18'd65536);
    sample_at(18'h1FFFF, 18'h1FFFF);
    sample_at(18'h20000, 18'h3FFFF);
    sample_at(18'd32768, 18'h20000);
    sample_at(18'd65536, 18'd0);

    for (int ph = 0; ph < PHASES; ph++) begin
      quiesce();
      case (ph)
        0: configure(9'd1, 9'd1, 1'b0);
        1: configure(9'd0, 9'd0, 1'b1);
        2: configure(9'd511, 9'd300, 1'b0);
        3: configure(9'd256, 9'd1, 1'b1);
        4: configure(9'd1, 9'd256, 1'b0);
        5: configure(9'd2, 9'd3, 1'b1);
        6: configure(9'd256, 9'd256, 1'b1);
        default: configure(SIZE_W'($urandom_range(1, 24)), SIZE_W'($urandom_range(1, 24)),
                           1'($urandom_range(0, 1)));
      endcase
      steady = (ph % 3 == 2);
      phase_end = sent_items + PHASE_ITEMS;
      phase_n = 0;
      while (sent_items < phase_end) begin
        if (ph == 4 && phase_n == 20) squeeze_req <= 1'b1;
        random_item();
        phase_n++;
      end
    end

    quiesce();
    repeat (32) @(posedge clk);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
